@@ hw/rtl/vfr_pkg.sv @@
// Shared constants, phase and event codes, and the result record
// for the variable-length frame receiver. No dependencies.
package vfr_pkg;

  localparam int DEF_COUNT_BITS = 16;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;

  // Receive phases
  localparam logic [3:0] PH_WAIT   = 4'd0;
  localparam logic [3:0] PH_LEN    = 4'd1;
  localparam logic [3:0] PH_VERIFY = 4'd2;
  localparam logic [3:0] PH_HDR    = 4'd3;
  localparam logic [3:0] PH_CTRL   = 4'd4;
  localparam logic [3:0] PH_ADDR   = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CSUM   = 4'd7;
  localparam logic [3:0] PH_END    = 4'd8;

  // Result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_ACCEPT   = 3'd2;
  localparam logic [2:0] EV_LENGTH   = 3'd3;
  localparam logic [2:0] EV_HEADER   = 3'd4;
  localparam logic [2:0] EV_CHECKSUM = 3'd5;
  localparam logic [2:0] EV_END      = 3'd6;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  control_field;
    logic [7:0]  address_field;
    logic [7:0]  frame_length;
    logic [15:0] frames_received;
  } vfr_result_t;

endpackage

@@ hw/rtl/vfr_core.sv @@
// Frame state machine: holds the receive state and works out one
// result per stepped byte. Depends on vfr_pkg.
module vfr_core import vfr_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output vfr_result_t res
);

  logic [3:0]            phase, phase_next;
  logic [7:0]            length_seen, length_seen_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [7:0]            data_position, data_position_next;
  logic [7:0]            control_seen, control_seen_next;
  logic [7:0]            address_seen, address_seen_next;
  logic [COUNT_BITS-1:0] frame_counter, frame_counter_next;
  logic [7:0]            pos_inc;
  logic                  abort;

  assign pos_inc = data_position + 8'd1;

  always_comb begin
    phase_next         = phase;
    length_seen_next   = length_seen;
    running_sum_next   = running_sum;
    data_position_next = data_position;
    control_seen_next  = control_seen;
    address_seen_next  = address_seen;
    frame_counter_next = frame_counter;
    abort              = 1'b0;
    res                = '0;

    unique case (phase)
      PH_WAIT: begin
        phase_next = (rx_byte == START_BYTE) ? PH_LEN : PH_WAIT;
      end
      PH_LEN: begin
        length_seen_next = rx_byte;
        phase_next       = PH_VERIFY;
      end
      PH_VERIFY: begin
        if (rx_byte == length_seen) begin
          phase_next = PH_HDR;
        end else begin
          res.event_res = EV_LENGTH;
          abort         = 1'b1;
        end
      end
      PH_HDR: begin
        if (rx_byte == START_BYTE) begin
          phase_next = PH_CTRL;
        end else begin
          res.event_res = EV_HEADER;
          abort         = 1'b1;
        end
      end
      PH_CTRL: begin
        control_seen_next = rx_byte;
        running_sum_next  = rx_byte;
        phase_next        = PH_ADDR;
      end
      PH_ADDR: begin
        address_seen_next = rx_byte;
        running_sum_next  = running_sum + rx_byte;
        if (length_seen > 8'd2) begin
          data_position_next = '0;
          phase_next         = PH_DATA;
        end else begin
          phase_next = PH_CSUM;
        end
      end
      PH_DATA: begin
        res.event_res      = EV_PAYLOAD;
        res.payload_byte   = rx_byte;
        res.payload_index  = data_position;
        running_sum_next   = running_sum + rx_byte;
        data_position_next = pos_inc;
        // length is above two here, so no underflow
        if (pos_inc >= length_seen - 8'd2) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (rx_byte == running_sum) begin
          phase_next = PH_END;
        end else begin
          res.event_res = EV_CHECKSUM;
          abort         = 1'b1;
        end
      end
      PH_END: begin
        if (rx_byte == END_BYTE) begin
          frame_counter_next = frame_counter + 1'b1;
          res.event_res      = EV_ACCEPT;
          res.control_field  = control_seen;
          res.address_field  = address_seen;
          res.frame_length   = length_seen;
          phase_next         = PH_WAIT;
        end else begin
          res.event_res = EV_END;
          abort         = 1'b1;
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase

    // offending byte may itself open a new frame
    if (abort) begin
      phase_next = (rx_byte == START_BYTE) ? PH_LEN : PH_WAIT;
    end

    res.frames_received = 16'(frame_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      length_seen   <= '0;
      running_sum   <= '0;
      data_position <= '0;
      control_seen  <= '0;
      address_seen  <= '0;
      frame_counter <= '0;
    end else if (step) begin
      phase         <= phase_next;
      length_seen   <= length_seen_next;
      running_sum   <= running_sum_next;
      data_position <= data_position_next;
      control_seen  <= control_seen_next;
      address_seen  <= address_seen_next;
      frame_counter <= frame_counter_next;
    end
  end

`ifndef SYNTHESIS
  a_count_on_accept: assert property (@(posedge clk) disable iff (rst)
    step && res.event_res == EV_ACCEPT
    |=> frame_counter == COUNT_BITS'($past(frame_counter) + 1'b1))
    else $error("frame counter did not advance on accepted frame");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(step && res.event_res == EV_ACCEPT) |=> $stable(frame_counter))
    else $error("frame counter moved without an accepted frame");

  a_abort_restart: assert property (@(posedge clk) disable iff (rst)
    step && abort |=> (phase == PH_WAIT || phase == PH_LEN))
    else $error("abort did not return to start search");
`endif

endmodule

@@ hw/rtl/variable_frame_receiver_unit.sv @@
// Top level of the variable-length frame receiver: input register,
// output register and handshake. Depends on vfr_pkg and vfr_core.
//
// Use:
//   Input channel in_valid/in_ready carries one received serial byte
//   (rx_byte) per request. Output channel out_valid/out_ready carries
//   exactly one result per byte: an event code plus payload byte/index
//   on data bytes, control/address/length on an accepted frame, and
//   the frame count after that byte in every result.
//   An accepted byte is held in the input register, then stepped into the
//   output register. Throughput: one byte per cycle while the output is
//   not stalled; the state step is a single pass of the frame state
//   machine between the two registers.
//   Stall: while out_ready is low the output register holds; the input
//   register still takes one more byte, then in_ready drops.
//   Reset: synchronous, clears both valid flags, the phase (back to
//   start-byte search), the frame fields and the frame counter.
//   Errors (length mismatch, bad header, checksum, bad end) abort the
//   frame and the offending byte is checked again as a start byte.
module variable_frame_receiver_unit import vfr_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [7:0]  control_field,
  output logic [7:0]  address_field,
  output logic [7:0]  frame_length,
  output logic [15:0] frames_received
);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  // output register
  vfr_result_t out_res;
  vfr_result_t step_res;

  logic out_load;   // output register free to take a new result
  logic s1_adv;     // held byte is stepped this cycle

  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || s1_adv;

  vfr_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .rx_byte (s1_byte),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= step_res;
    end
  end

  assign event_res       = out_res.event_res;
  assign payload_byte    = out_res.payload_byte;
  assign payload_index   = out_res.payload_index;
  assign control_field   = out_res.control_field;
  assign address_field   = out_res.address_field;
  assign frame_length    = out_res.frame_length;
  assign frames_received = out_res.frames_received;

`ifndef SYNTHESIS
  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte))
    else $error("held byte lost while output stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("payload fields set on a non-payload result");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("stepped byte gave no result");
`endif

endmodule

@@ sim/variable_frame_receiver_unit_tb.sv @@
// Self-checking testbench for variable_frame_receiver_unit: a directed table and then
// random frames, with the results checked against a cycle-free frame predictor.
// Depends on vfr_pkg and the receiver RTL only.
module variable_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfr_pkg::*;

  localparam int N_DIRECTED   = 31;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 16;      // idle time after the last result, as margin
  localparam int CYCLE_LIMIT  = 1000000;

  // One row of the directed table. Where known is set, the expected result is
  // typed in (event and frame count, every other field zero); otherwise the
  // predictor provides it.
  typedef struct packed {
    logic [7:0]  rx;
    logic        known;
    logic [2:0]  ev;
    logic [15:0] frames;
  } stim_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  control_field;
  logic [7:0]  address_field;
  logic [7:0]  frame_length;
  logic [15:0] frames_received;

  // Predictor state: our own copy of the receiver's frame registers.
  logic [3:0]  rx_phase;
  logic [7:0]  len_seen;
  logic [7:0]  csum_acc;
  logic [7:0]  data_pos;
  logic [7:0]  ctrl_seen;
  logic [7:0]  addr_seen;
  logic [15:0] frame_count;

  vfr_result_t pending_results[$];     // expected results, oldest first
  logic [7:0]  frame_bytes[$];         // bytes of the frame being built
  stim_row_t   directed_rows [0:N_DIRECTED-1];

  int          mismatches   = 0;
  int          sent_count   = 0;
  int          result_count = 0;
  int          cycles       = 0;
  int          sender_calm  = 0;
  int          sink_calm    = 0;
  int          sink_stall   = 0;
  vfr_result_t sink_want;
  vfr_result_t sink_got;

  variable_frame_receiver_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_res       (event_res),
    .payload_byte    (payload_byte),
    .payload_index   (payload_index),
    .control_field   (control_field),
    .address_field   (address_field),
    .frame_length    (frame_length),
    .frames_received (frames_received)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("variable_frame_receiver_unit_tb failed");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long, and
  // occasional calm stretches where neither side idles at all.
  function automatic int idle_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Frame predictor: advances the receiver state by one byte and gives the
  // result that byte should produce.
  task automatic frame_step(input logic [7:0] b, output vfr_result_t r);
    logic abort;
    r     = '0;
    abort = 1'b0;
    case (rx_phase)
      PH_WAIT: begin
        rx_phase = (b == START_BYTE) ? PH_LEN : PH_WAIT;
      end
      PH_LEN: begin
        len_seen = b;
        rx_phase = PH_VERIFY;
      end
      PH_VERIFY: begin
        if (b == len_seen) begin
          rx_phase = PH_HDR;
        end else begin
          r.event_res = EV_LENGTH;
          abort = 1'b1;
        end
      end
      PH_HDR: begin
        if (b == START_BYTE) begin
          rx_phase = PH_CTRL;
        end else begin
          r.event_res = EV_HEADER;
          abort = 1'b1;
        end
      end
      PH_CTRL: begin
        ctrl_seen = b;
        csum_acc  = b;
        rx_phase  = PH_ADDR;
      end
      PH_ADDR: begin
        addr_seen = b;
        csum_acc  = csum_acc + b;
        // short length: no data, checksum follows the address
        if (len_seen > 8'd2) begin
          data_pos = 8'd0;
          rx_phase = PH_DATA;
        end else begin
          rx_phase = PH_CSUM;
        end
      end
      PH_DATA: begin
        r.event_res     = EV_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = data_pos;
        csum_acc = csum_acc + b;
        data_pos = data_pos + 8'd1;
        if (data_pos >= len_seen - 8'd2) rx_phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (b == csum_acc) begin
          rx_phase = PH_END;
        end else begin
          r.event_res = EV_CHECKSUM;
          abort = 1'b1;
        end
      end
      PH_END: begin
        if (b == END_BYTE) begin
          frame_count     = frame_count + 16'd1;
          r.event_res     = EV_ACCEPT;
          r.control_field = ctrl_seen;
          r.address_field = addr_seen;
          r.frame_length  = len_seen;
          rx_phase = PH_WAIT;
        end else begin
          r.event_res = EV_END;
          abort = 1'b1;
        end
      end
      default: begin
        rx_phase = PH_WAIT;
      end
    endcase
    // aborting byte gets a second look as a start byte
    if (abort) rx_phase = (b == START_BYTE) ? PH_LEN : PH_WAIT;
    r.frames_received = frame_count;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offers one request and holds it until taken; the expectation is queued at
  // the accepting edge. Valid stays high straight into the next request when
  // the next gap is zero.
  task automatic send_byte(input logic [7:0] b, input logic known, input vfr_result_t want);
    vfr_result_t pred;
    int          gap;
    rx_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_step(b, pred);
    pending_results.push_back(known ? want : pred);
    sent_count++;
    gap = idle_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower valid and hold off until every expected result has come out.
  // Valid is only lowered while still high, so a request that follows at once
  // never meets a second write of valid in the same step.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] d;
    do d = 8'($urandom); while (d == avoid);
    return d;
  endfunction

  // Builds one frame into frame_bytes. Most are well formed with random
  // content; the rest carry one flaw and stop at the flawed byte, or are cut
  // short, and some are followed by line noise.
  task automatic build_frame(input logic force_max);
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] d;
    int         r;
    int         flaw;
    int         i;
    int         cut;
    frame_bytes.delete();
    r = $urandom_range(0, 99);
    if (force_max)   len = 8'hFF;
    else if (r < 10) len = 8'($urandom_range(0, 2));
    else if (r < 90) len = 8'($urandom_range(3, 12));
    else if (r < 98) len = 8'($urandom_range(13, 60));
    else             len = 8'($urandom_range(200, 255));
    flaw = force_max ? 99 : $urandom_range(0, 99);

    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(len);
    if (flaw < 5) begin
      frame_bytes.push_back(len ^ 8'($urandom_range(1, 255)));   // length mismatch
      return;
    end
    frame_bytes.push_back(len);
    if (flaw < 10) begin
      frame_bytes.push_back(byte_other_than(START_BYTE));         // bad second start
      return;
    end
    frame_bytes.push_back(START_BYTE);
    d = 8'($urandom);
    frame_bytes.push_back(d);
    sum = d;
    d = 8'($urandom);
    frame_bytes.push_back(d);
    sum = sum + d;
    for (i = 0; i < int'(len) - 2; i++) begin
      d = 8'($urandom);
      frame_bytes.push_back(d);
      sum = sum + d;
    end
    if (flaw < 16) begin
      frame_bytes.push_back(sum ^ 8'($urandom_range(1, 255)));   // checksum error
      return;
    end
    frame_bytes.push_back(sum);
    if (flaw < 22) begin
      // bad end byte, a quarter of them a start byte to be picked up again
      frame_bytes.push_back(($urandom_range(0, 3) == 0) ? START_BYTE
                                                        : byte_other_than(END_BYTE));
      return;
    end
    frame_bytes.push_back(END_BYTE);
    if (flaw < 28) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);           // truncated frame
      repeat (cut) void'(frame_bytes.pop_back());
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // Result side: random back-pressure, and every accepted result compared with
  // the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        sink_got = '{event_res, payload_byte, payload_index, control_field,
                     address_field, frame_length, frames_received};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, event_res", int'(event_res), -1);
        end else begin
          sink_want = pending_results.pop_front();
          check_field("event_res", sink_got.event_res, sink_want.event_res);
          check_field("payload_byte", sink_got.payload_byte, sink_want.payload_byte);
          check_field("payload_index", sink_got.payload_index, sink_want.payload_index);
          check_field("control_field", sink_got.control_field, sink_want.control_field);
          check_field("address_field", sink_got.address_field, sink_want.address_field);
          check_field("frame_length", sink_got.frame_length, sink_want.frame_length);
          check_field("frames_received", sink_got.frames_received,
                      sink_want.frames_received);
        end
        result_count++;
      end
      if (sink_stall > 0) begin
        out_ready <= 1'b0;
        sink_stall--;
      end else begin
        out_ready <= 1'b1;
        sink_stall = idle_gap(sink_calm);
      end
    end
  end

  initial begin
    int          row;
    int          frame_no;
    vfr_result_t want;

    rx_phase    = PH_WAIT;
    len_seen    = 8'd0;
    csum_acc    = 8'd0;
    data_pos    = 8'd0;
    ctrl_seen   = 8'd0;
    addr_seen   = 8'd0;
    frame_count = 16'd0;

    directed_rows = '{
      '{8'h00, 1'b1, EV_NONE,     16'd0},  // idle byte straight after reset
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h05, 1'b0, EV_NONE,     16'd0},
      '{8'h06, 1'b1, EV_LENGTH,   16'd0},  // repeated length differs
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h00, 1'b0, EV_NONE,     16'd0},  // length zero
      '{8'h00, 1'b0, EV_NONE,     16'd0},
      '{8'h67, 1'b1, EV_HEADER,   16'd0},  // second start byte wrong
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h02, 1'b0, EV_NONE,     16'd0},  // short frame, no data
      '{8'h02, 1'b0, EV_NONE,     16'd0},
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'hFF, 1'b0, EV_NONE,     16'd0},  // control and address at maximum
      '{8'hFF, 1'b0, EV_NONE,     16'd0},
      '{8'hFE, 1'b0, EV_NONE,     16'd0},  // checksum wraps
      '{8'h16, 1'b0, EV_NONE,     16'd0},  // frame accepted
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h03, 1'b0, EV_NONE,     16'd0},  // one data byte
      '{8'h03, 1'b0, EV_NONE,     16'd0},
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h00, 1'b0, EV_NONE,     16'd0},
      '{8'h00, 1'b0, EV_NONE,     16'd0},
      '{8'h80, 1'b0, EV_NONE,     16'd0},  // payload byte, index zero
      '{8'h80, 1'b0, EV_NONE,     16'd0},
      '{8'h68, 1'b1, EV_END,      16'd1},  // bad end that is itself a start byte
      '{8'h01, 1'b0, EV_NONE,     16'd0},  // so this byte is a length
      '{8'h01, 1'b0, EV_NONE,     16'd0},
      '{8'h68, 1'b0, EV_NONE,     16'd0},
      '{8'h00, 1'b0, EV_NONE,     16'd0},
      '{8'h00, 1'b0, EV_NONE,     16'd0},
      '{8'h01, 1'b1, EV_CHECKSUM, 16'd1}   // checksum should be zero
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < N_DIRECTED; row++) begin
      want                 = '0;
      want.event_res       = directed_rows[row].ev;
      want.frames_received = directed_rows[row].frames;
      send_byte(directed_rows[row].rx, directed_rows[row].known, want);
    end

    // sender holds off until the receiver has handed back everything
    drain_results();

    frame_no = 0;
    while (sent_count < N_DIRECTED + RANDOM_ITEMS) begin
      build_frame(frame_no == 10);     // one frame of the longest length
      while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front(), 1'b0, '0);
      if ($urandom_range(0, 39) == 0) drain_results();
      frame_no++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("variable_frame_receiver_unit_tb passed");
    end else begin
      $display("variable_frame_receiver_unit_tb failed");
    end
    $finish;
  end

endmodule
